/* rtl/fic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_pkg
// Shared types, constants and CRC table helper for the frame integrity checker.
// ----------------------------------------------------------------------------
package fic_pkg;

    localparam int MAX_DIM_DEF  = 8192;
    localparam int SAMPLE_BYTES = 65536;

    localparam int DIM_FIELD_W = 14;
    localparam int CFG_IDX_W   = 2;
    localparam int PIX_W       = 32;
    localparam int PIX_BYTES   = 4;
    localparam int NB_W        = $clog2(PIX_BYTES + 1);
    localparam int CNT_W       = 27;
    localparam int BYTE_OFF_W  = CNT_W + 2;
    localparam int SUM_W       = 34;
    localparam int CRC_W       = 32;
    localparam int HASH_W      = 64;
    localparam int PCT_W       = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // byte lanes of a packed pixel
    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;
    localparam int LANE_ALPHA = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CRC_W-1:0]  CRC_POLY  = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    localparam int PCT_SCALE     = 100;
    localparam int PCT_MAX       = 100;
    localparam int BLACK_LIMIT   = 99;
    localparam int VISIBLE_SCALE = 1000;

    typedef enum logic [1:0] {
        FAIL_NONE     = 2'd0,
        FAIL_ZERO_DIM = 2'd1,
        FAIL_BLACK    = 2'd2
    } fail_kind_t;

    typedef enum logic [1:0] {
        ITEM_MID  = 2'd0,
        ITEM_LAST = 2'd1,
        ITEM_ZERO = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]   index;
        logic [DIM_FIELD_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } pixel_item_t;

    typedef struct packed {
        logic              dead_frame;
        fail_kind_t        failure_kind;
        logic [CRC_W-1:0]  frame_crc;
        logic [HASH_W-1:0] frame_hash;
        logic [CNT_W-1:0]  dark_pixels;
        logic [CNT_W-1:0]  lit_pixels;
        logic [SUM_W-1:0]  red_sum;
        logic [SUM_W-1:0]  green_sum;
        logic [SUM_W-1:0]  blue_sum;
        logic [SUM_W-1:0]  alpha_sum;
        logic [PCT_W-1:0]  visible_percent;
    } result_item_t;

    // classified pixel on its way from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        item_kind_t       kind;
        logic [NB_W-1:0]  crc_bytes;
    } work_item_t;

    // end-of-frame totals handed to the finisher
    typedef struct packed {
        logic                            zero_dim;
        logic [CRC_W-1:0]                crc;
        logic [HASH_W-1:0]               hash;
        logic [CNT_W-1:0]                black;
        logic [CNT_W-1:0]                visible;
        logic [PIX_BYTES-1:0][SUM_W-1:0] sums;
    } frame_snap_t;

    // Slice table m: one byte followed by m zero bytes through the reflected CRC.
    function automatic logic [CRC_W-1:0] crc_tab_entry(input int m, input logic [7:0] x);
        logic [CRC_W-1:0] c;
        c = {24'd0, x};
        for (int k = 0; k < 8 * PIX_BYTES; k++) begin
            if (k < 8 * (m + 1)) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

endpackage

/* rtl/fic_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface fic_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/fic_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_front
// Configuration registers, pixel position tracking and pixel classification.
// ----------------------------------------------------------------------------
module fic_front #(
    parameter int MAX_DIM = fic_pkg::MAX_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fic_stream_if.sink                        cfg,
    fic_stream_if.sink                        pixels,
    output logic                              q_valid,
    output fic_pkg::work_item_t               q_data,
    input  logic                              q_ready,
    output logic                              restart,
    output logic [2*$clog2(MAX_DIM+1)-1:0]    total
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int TOT_W  = 2 * DIM_W;
    localparam int DCMP_W = fic_pkg::DIM_FIELD_W + 2;
    localparam int TCMP_W = (TOT_W > fic_pkg::CNT_W) ? TOT_W : fic_pkg::CNT_W;
    localparam logic [fic_pkg::BYTE_OFF_W-1:0] SAMPLE_LIM =
        fic_pkg::BYTE_OFF_W'(fic_pkg::SAMPLE_BYTES);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [fic_pkg::DIM_FIELD_W-1:0] d);
        logic [DCMP_W-1:0] dx;
        dx = DCMP_W'(d);
        if (dx > DCMP_W'(MAX_DIM)) begin
            dx = DCMP_W'(MAX_DIM);
        end
        return dx[DIM_W-1:0];
    endfunction

    logic [DIM_W-1:0]               width_reg,  width_next;
    logic [DIM_W-1:0]               height_reg, height_next;
    logic [TOT_W-1:0]               total_reg,  total_next;
    logic [fic_pkg::CNT_W-1:0]      idx_reg,    idx_next;
    logic [fic_pkg::CNT_W-1:0]      idx_inc;
    logic [fic_pkg::BYTE_OFF_W-1:0] byte_base;
    logic [fic_pkg::BYTE_OFF_W-1:0] byte_left;
    logic [fic_pkg::NB_W-1:0]       crc_bytes;
    fic_pkg::item_kind_t            kind;
    logic                           cfg_we;
    logic                           px_xfer;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid &&
                       (cfg.data.index == fic_pkg::REG_FRAME_WIDTH ||
                        cfg.data.index == fic_pkg::REG_FRAME_HEIGHT);
    assign restart   = cfg_we;
    assign total     = total_reg;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we && cfg.data.index == fic_pkg::REG_FRAME_WIDTH) begin
            width_next = clamp_dim(cfg.data.value);
        end
        if (cfg_we && cfg.data.index == fic_pkg::REG_FRAME_HEIGHT) begin
            height_next = clamp_dim(cfg.data.value);
        end
        total_next = TOT_W'(width_next) * TOT_W'(height_next);
    end

    // how many of this pixel's bytes still fall inside the CRC sample span
    always_comb begin
        byte_base = {idx_reg, 2'b00};
        byte_left = SAMPLE_LIM - byte_base;
        if (byte_base >= SAMPLE_LIM) begin
            crc_bytes = '0;
        end else if (byte_left >= fic_pkg::BYTE_OFF_W'(fic_pkg::PIX_BYTES)) begin
            crc_bytes = fic_pkg::NB_W'(fic_pkg::PIX_BYTES);
        end else begin
            crc_bytes = byte_left[fic_pkg::NB_W-1:0];
        end
    end

    always_comb begin
        idx_inc = idx_reg + 1'b1;
        if (total_reg == '0) begin
            kind = fic_pkg::ITEM_ZERO;
        end else if (TCMP_W'(idx_inc) >= TCMP_W'(total_reg)) begin
            kind = fic_pkg::ITEM_LAST;
        end else begin
            kind = fic_pkg::ITEM_MID;
        end
        idx_next = (kind == fic_pkg::ITEM_MID) ? idx_inc : '0;
    end

    assign pixels.ready     = q_ready;
    assign px_xfer          = pixels.valid && q_ready;
    assign q_valid          = pixels.valid;
    assign q_data.pixel     = pixels.data.pixel;
    assign q_data.kind      = kind;
    assign q_data.crc_bytes = crc_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            total_reg  <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg  <= width_next;
                height_reg <= height_next;
                total_reg  <= total_next;
                idx_reg    <= '0;
            end
            else if (px_xfer)
            begin
                idx_reg <= idx_next;
            end
        end
    end

endmodule

/* rtl/fic_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_queue
// Small FIFO of classified pixels between the front and the back end.
// ----------------------------------------------------------------------------
module fic_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fic_pkg::work_item_t in_data,
    output logic                in_ready,
    output logic                out_valid,
    output fic_pkg::work_item_t out_data,
    input  logic                out_ready
);

    fic_pkg::work_item_t          mem [fic_pkg::QUEUE_DEPTH];
    logic [fic_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [fic_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [fic_pkg::QCNT_W-1:0]   count_reg;
    logic                         push;
    logic                         pop;

    assign in_ready  = (count_reg != fic_pkg::QCNT_W'(fic_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [fic_pkg::QPTR_W-1:0] ptr_inc(input logic [fic_pkg::QPTR_W-1:0] p);
        if (p == fic_pkg::QPTR_W'(fic_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/fic_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_back
// Per-pixel accumulators: CRC-32, FNV-1a hash, black/visible counts, sums.
// ----------------------------------------------------------------------------
module fic_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  logic                 q_valid,
    input  fic_pkg::work_item_t  q_data,
    output logic                 q_ready,
    output logic                 snap_valid,
    output fic_pkg::frame_snap_t snap,
    input  logic                 snap_ready
);

    logic [fic_pkg::CRC_W-1:0] crc_tab [fic_pkg::PIX_BYTES][256];

    for (genvar m = 0; m < fic_pkg::PIX_BYTES; m++) begin : g_tab
        for (genvar v = 0; v < 256; v++) begin : g_ent
            assign crc_tab[m][v] = fic_pkg::crc_tab_entry(m, 8'(v));
        end
    end

    logic [fic_pkg::CRC_W-1:0]                       crc_reg,   crc_upd;
    logic [fic_pkg::HASH_W-1:0]                      hash_reg,  hash_upd;
    logic [fic_pkg::CNT_W-1:0]                       black_reg, black_upd;
    logic [fic_pkg::CNT_W-1:0]                       vis_reg,   vis_upd;
    logic [fic_pkg::PIX_BYTES-1:0][fic_pkg::SUM_W-1:0] sum_reg, sum_upd;
    logic [fic_pkg::HASH_W-1:0]                      hx;
    logic [fic_pkg::PIX_W-1:0]                       px;
    logic [fic_pkg::NB_W-1:0]                        nb;
    logic                                            pop;

    assign px = q_data.pixel;
    assign nb = q_data.crc_bytes;

    // slice-by-n CRC update over the nb low bytes of the pixel
    always_comb begin
        logic [1:0] sel;
        logic [7:0] x;
        sel     = '0;
        x       = '0;
        crc_upd = crc_reg >> {nb, 3'b000};
        for (int j = 0; j < fic_pkg::PIX_BYTES; j++) begin
            if (fic_pkg::NB_W'(j) < nb) begin
                sel     = 2'(nb - fic_pkg::NB_W'(j) - fic_pkg::NB_W'(1));
                x       = crc_reg[8*j +: 8] ^ px[8*j +: 8];
                crc_upd = crc_upd ^ crc_tab[sel][x];
            end
        end
    end

    // FNV prime is 2^40 + 0x1B3
    always_comb begin
        hx = hash_reg ^ {56'd0, px[7:0]};
        if (nb != '0) begin
            hash_upd = (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5)
                     + (hx << 4) + (hx << 1) + hx;
        end else begin
            hash_upd = hash_reg;
        end
    end

    always_comb begin
        for (int k = 0; k < fic_pkg::PIX_BYTES; k++) begin
            sum_upd[k] = sum_reg[k] + fic_pkg::SUM_W'(px[8*k +: 8]);
        end
        black_upd = black_reg;
        vis_upd   = vis_reg;
        if (px[23:0] == 24'd0) begin
            black_upd = black_reg + 1'b1;
        end else begin
            vis_upd = vis_reg + 1'b1;
        end
    end

    // frame-ending items wait until the finisher is free
    assign q_ready    = (q_data.kind == fic_pkg::ITEM_MID) || snap_ready;
    assign pop        = q_valid && q_ready;
    assign snap_valid = q_valid && (q_data.kind != fic_pkg::ITEM_MID);

    assign snap.zero_dim = (q_data.kind == fic_pkg::ITEM_ZERO);
    assign snap.crc      = crc_upd;
    assign snap.hash     = hash_upd;
    assign snap.black    = black_upd;
    assign snap.visible  = vis_upd;
    assign snap.sums     = sum_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= fic_pkg::CRC_INIT;
            hash_reg  <= fic_pkg::FNV_BASIS;
            black_reg <= '0;
            vis_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (restart || (pop && q_data.kind != fic_pkg::ITEM_MID))
            begin
                crc_reg   <= fic_pkg::CRC_INIT;
                hash_reg  <= fic_pkg::FNV_BASIS;
                black_reg <= '0;
                vis_reg   <= '0;
                sum_reg   <= '0;
            end
            else if (pop)
            begin
                crc_reg   <= crc_upd;
                hash_reg  <= hash_upd;
                black_reg <= black_upd;
                vis_reg   <= vis_upd;
                sum_reg   <= sum_upd;
            end
        end
    end

endmodule

/* rtl/fic_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_finish
// End-of-frame verdict: dead-frame tests, percent divider, result register.
// ----------------------------------------------------------------------------
module fic_finish #(
    parameter int MAX_DIM = fic_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           snap_valid,
    input  fic_pkg::frame_snap_t           snap,
    output logic                           snap_ready,
    input  logic [2*$clog2(MAX_DIM+1)-1:0] total,
    fic_stream_if.source                   results
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int TOT_W  = 2 * DIM_W;
    localparam int NUM_W  = fic_pkg::CNT_W + fic_pkg::PCT_W;
    localparam int DIV_W  = (NUM_W > TOT_W + fic_pkg::PCT_W) ? NUM_W : TOT_W + fic_pkg::PCT_W;
    localparam int PA_W   = fic_pkg::CNT_W + 10;
    localparam int PB_W   = TOT_W + fic_pkg::PCT_W;
    localparam int CMP_W  = (PA_W > PB_W) ? PA_W : PB_W;
    localparam int STEP_W = $clog2(fic_pkg::PCT_W);
    // result bits below dead_frame and failure_kind
    localparam int ZERO_TAIL_W = $bits(fic_pkg::result_item_t) - 1
                                 - $bits(fic_pkg::fail_kind_t);

    typedef enum logic [1:0] {
        FIN_IDLE,
        FIN_MUL,
        FIN_DIV,
        FIN_OUT
    } fin_state_t;

    fin_state_t                  state_reg;
    fic_pkg::frame_snap_t        snap_reg;
    fic_pkg::result_item_t       out_reg;
    logic [CMP_W-1:0]            black100_reg;
    logic [CMP_W-1:0]            total99_reg;
    logic [CMP_W-1:0]            vis1000_reg;
    logic [DIV_W-1:0]            rem_reg;
    logic [fic_pkg::PCT_W-1:0]   quot_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [DIV_W-1:0]            divisor;
    logic                        fits;
    logic [fic_pkg::PCT_W-1:0]   quot_next;
    logic                        dead_now;

    assign snap_ready    = (state_reg == FIN_IDLE);
    assign results.valid = (state_reg == FIN_OUT);
    assign results.data  = out_reg;

    // one quotient bit per cycle, high bit first
    always_comb begin
        divisor   = DIV_W'(total) << step_reg;
        fits      = (rem_reg >= divisor);
        quot_next = {quot_reg[fic_pkg::PCT_W-2:0], fits};
        dead_now  = (black100_reg > total99_reg) || (vis1000_reg < CMP_W'(total));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FIN_IDLE;
            snap_reg     <= '0;
            out_reg      <= '0;
            black100_reg <= '0;
            total99_reg  <= '0;
            vis1000_reg  <= '0;
            rem_reg      <= '0;
            quot_reg     <= '0;
            step_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                FIN_IDLE:
                begin
                    if (snap_valid)
                    begin
                        snap_reg <= snap;
                        if (snap.zero_dim)
                        begin
                            out_reg   <= {1'b1, fic_pkg::FAIL_ZERO_DIM, {ZERO_TAIL_W{1'b0}}};
                            state_reg <= FIN_OUT;
                        end
                        else
                        begin
                            state_reg <= FIN_MUL;
                        end
                    end
                end
                FIN_MUL:
                begin
                    black100_reg <= CMP_W'(snap_reg.black) * CMP_W'(fic_pkg::PCT_SCALE);
                    total99_reg  <= CMP_W'(total) * CMP_W'(fic_pkg::BLACK_LIMIT);
                    vis1000_reg  <= CMP_W'(snap_reg.visible) * CMP_W'(fic_pkg::VISIBLE_SCALE);
                    rem_reg      <= DIV_W'(snap_reg.visible) * DIV_W'(fic_pkg::PCT_SCALE);
                    quot_reg     <= '0;
                    step_reg     <= STEP_W'(fic_pkg::PCT_W - 1);
                    state_reg    <= FIN_DIV;
                end
                FIN_DIV:
                begin
                    if (fits)
                    begin
                        rem_reg <= rem_reg - divisor;
                    end
                    quot_reg <= quot_next;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        out_reg.dead_frame      <= dead_now;
                        out_reg.failure_kind    <= dead_now ? fic_pkg::FAIL_BLACK
                                                            : fic_pkg::FAIL_NONE;
                        out_reg.frame_crc       <= ~snap_reg.crc;
                        out_reg.frame_hash      <= snap_reg.hash;
                        out_reg.dark_pixels     <= snap_reg.black;
                        out_reg.lit_pixels      <= snap_reg.visible;
                        out_reg.red_sum         <= snap_reg.sums[fic_pkg::LANE_RED];
                        out_reg.green_sum       <= snap_reg.sums[fic_pkg::LANE_GREEN];
                        out_reg.blue_sum        <= snap_reg.sums[fic_pkg::LANE_BLUE];
                        out_reg.alpha_sum       <= snap_reg.sums[fic_pkg::LANE_ALPHA];
                        out_reg.visible_percent <= quot_next;
                        state_reg               <= FIN_OUT;
                    end
                end
                FIN_OUT:
                begin
                    if (results.ready)
                    begin
                        state_reg <= FIN_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= FIN_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/frame_integrity_checker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_integrity_checker_unit
// Frame CRC-32 / FNV-1a signature and dead-frame checker, top level.
// ----------------------------------------------------------------------------
// Accepts one ARGB pixel per clock when not stalled, rows in order, and gives
// one result per frame of frame_width x frame_height pixels (dimensions above
// MAX_DIM are saturated). The front end classifies each pixel and pushes it
// into a two-entry queue; the back end folds up to four CRC bytes and one
// hash step (only within the first SAMPLE_BYTES bytes of a frame), the counts
// and the channel sums per pixel. After a frame's last pixel the finisher
// passes a multiply state, divide steps that each yield one percent bit, and
// the output state; while it computes or waits on results.ready the next
// frame's pixels keep streaming, and only the next frame-ending pixel stalls.
// With a zero dimension every pixel yields a failure result, and the next one
// is taken only after the previous result has been sent. Writing either
// dimension restarts the frame; write only while no frame is in progress.
// ----------------------------------------------------------------------------
module frame_integrity_checker_unit #(
    parameter int MAX_DIM = fic_pkg::MAX_DIM_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fic_stream_if.sink   cfg,
    fic_stream_if.sink   pixels,
    fic_stream_if.source results
);

    localparam int TOT_W = 2 * $clog2(MAX_DIM + 1);

    logic                 fq_valid;
    fic_pkg::work_item_t  fq_data;
    logic                 fq_ready;
    logic                 qb_valid;
    fic_pkg::work_item_t  qb_data;
    logic                 qb_ready;
    logic                 restart;
    logic [TOT_W-1:0]     total;
    logic                 snap_valid;
    logic                 snap_ready;
    fic_pkg::frame_snap_t snap;

    fic_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pixels  (pixels),
        .q_valid (fq_valid),
        .q_data  (fq_data),
        .q_ready (fq_ready),
        .restart (restart),
        .total   (total)
    );

    fic_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_data   (fq_data),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_data  (qb_data),
        .out_ready (qb_ready)
    );

    fic_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .q_valid    (qb_valid),
        .q_data     (qb_data),
        .q_ready    (qb_ready),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    fic_finish #(
        .MAX_DIM (MAX_DIM)
    ) u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .total      (total),
        .results    (results)
    );

endmodule

/* rtl/fic_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fic_checker
// Port-level assertions on the checker's result channel, bound to the top.
// ----------------------------------------------------------------------------
module fic_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_ready,
    input fic_pkg::result_item_t res_data
);

    // a stalled result holds until its transfer
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_dead_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.dead_frame == (res_data.failure_kind != fic_pkg::FAIL_NONE))
        else $error("dead_frame disagrees with failure_kind");

    a_zero_dim_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.failure_kind == fic_pkg::FAIL_ZERO_DIM |->
            res_data.frame_crc == '0 && res_data.frame_hash == '0 &&
            res_data.dark_pixels == '0 && res_data.lit_pixels == '0 &&
            res_data.red_sum == '0 && res_data.visible_percent == '0)
        else $error("zero-dimension result carries frame data");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.visible_percent <= fic_pkg::PCT_W'(fic_pkg::PCT_MAX))
        else $error("visible_percent above 100");

endmodule

bind frame_integrity_checker_unit fic_checker u_fic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);
